// ===== sv/mlp_pkg.sv =====
// package for the one-hidden-layer perceptron engine
// holds the tanh table, request codes and shared types; no dependencies
package mlp_pkg;

	localparam int Q_FRAC = 16;

	// request type carried in tuser
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_INFER = 1'b1;

	// tanh(k/8) in unsigned q0.16, k = 0..32
	localparam logic [15:0] TANH_TAB [0:32] = '{
		16'd0, 16'd8150, 16'd16051, 16'd23485, 16'd30285, 16'd36346, 16'd41625, 16'd46131,
		16'd49912, 16'd53038, 16'd55593, 16'd57668, 16'd59320, 16'd60643, 16'd61694,
		16'd62524, 16'd63179, 16'd63693, 16'd64096, 16'd64412, 16'd64659, 16'd64852,
		16'd65003, 16'd65120, 16'd65212, 16'd65283, 16'd65339, 16'd65383, 16'd65417,
		16'd65443, 16'd65464, 16'd65480, 16'd65492
	};

	// saturate a 64-bit signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) r = 32'sh7fffffff;
		else if (v < -64'sd2147483648) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

	// request to the divider
	typedef struct packed {
		logic               start;
		logic signed [63:0] num;
		logic signed [32:0] den;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic signed [63:0] quo;
	} div_rsp_t;

endpackage

// ===== sv/mlp_ram.sv =====
// generic single-port write, single-port registered read memory
// no dependencies
module mlp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// ===== sv/mlp_div.sv =====
// restoring divider, one quotient bit per cycle, truncates toward zero
// depends on mlp_pkg
module mlp_div (
	input  logic              clk,
	input  logic              arst_n,
	input  mlp_pkg::div_req_t req,
	output mlp_pkg::div_rsp_t rsp
);
	logic [63:0] rem_q, quo_q;
	logic [63:0] num_abs;
	logic [31:0] den_abs, den_q;
	logic        neg_q, busy_q, done_q;
	logic [5:0]  cnt_q;
	logic [64:0] trial;
	logic [63:0] rem_sh;

	assign num_abs = req.num[63] ? 64'(-req.num) : req.num;
	assign den_abs = 32'(req.den[32] ? -req.den : req.den);
	assign rem_sh  = {rem_q[62:0], quo_q[63]};
	assign trial   = {1'b0, rem_sh} - {33'd0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= num_abs;
			den_q <= den_abs;
			neg_q <= req.num[63] ^ req.den[32];
		end else if (busy_q) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = neg_q ? 64'(-quo_q) : quo_q;
endmodule

// ===== sv/mlp_one_hidden_layer_inference.sv =====
// top level of the one-hidden-layer perceptron inference engine
// depends on mlp_pkg, mlp_ram, mlp_div
//
// usage: one input channel (s_axis_*) carries load words and sample words.
// tuser = req_type: 0 loads coef_value into coefficient address coef_index,
// 1 runs inference on the eight features in tdata. the output channel
// (m_axis_*) returns OUTPUTS words per sample, tlast on the final one.
// coefficient layout: min[f], max[f], hidden weights, hidden biases, output
// weights, output biases, all q16.16.
// loads can follow back to back. a sample runs normalization (two reads,
// of min and max, plus a 64-step divide per feature, no divide when max
// equals min), then hidden sums and tanh, then output sums. the shared
// 32x32 multiplier and the bit-serial divider set the sample time.
// s_axis_tready is low while a sample runs. the result register stalls the
// sequencer when the receiver holds m_axis_tready low; nothing is lost.
// reset clears the sequencer; the coefficient memory is not cleared and
// must be loaded before use.
module mlp_one_hidden_layer_inference #(
	parameter int FEATURES   = 8,
	parameter int HIDDEN     = 12,
	parameter int OUTPUTS    = 1,
	parameter int COEF_DEPTH = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// coef_index[7:0], coef_value[39:8], feature_0..7 [71:40]..[295:264]
	input  logic [295:0] s_axis_tdata,
	// req_type
	input  logic         s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// pred_value[31:0], output_index[33:32], pad
	output logic [39:0]  m_axis_tdata,
	output logic         m_axis_tlast
);
	localparam int AW      = $clog2(COEF_DEPTH);
	localparam int MAX_B   = FEATURES;
	localparam int HW_B    = 2 * FEATURES;
	localparam int HB_B    = HW_B + HIDDEN * FEATURES;
	localparam int OW_B    = HB_B + HIDDEN;
	localparam int OB_B    = OW_B + OUTPUTS * HIDDEN;
	localparam int FW      = (FEATURES > 1) ? $clog2(FEATURES) : 1;
	localparam int HWD     = (HIDDEN > 1) ? $clog2(HIDDEN) : 1;
	localparam int OWD     = (OUTPUTS > 1) ? $clog2(OUTPUTS) : 1;

	// sequencer states
	typedef enum logic [11:0] {
		ST_IDLE  = 12'b000000000001,
		ST_NRD   = 12'b000000000010, // read min, max
		ST_NDIV  = 12'b000000000100, // wait for divide
		ST_MRD   = 12'b000000001000, // issue weight read
		ST_MUL   = 12'b000000010000, // multiply
		ST_ACC   = 12'b000000100000, // accumulate
		ST_BIAS  = 12'b000001000000, // add bias
		ST_TANH  = 12'b000010000000, // tanh lookup
		ST_TMUL  = 12'b000100000000, // tanh interpolation product
		ST_TEND  = 12'b001000000000,
		ST_OUT   = 12'b010000000000,
		ST_WAIT  = 12'b100000000000
	} state_t;

	state_t state_q;
	logic              layer_q; // 0 hidden, 1 output
	logic [3:0]        nrd_q;
	logic [FW-1:0]     f_q;
	logic [HWD-1:0]    h_q;
	logic [OWD-1:0]    o_q;
	logic signed [31:0] feat_q [0:FEATURES-1];
	logic signed [31:0] xn_q   [0:FEATURES-1];
	logic signed [31:0] he_q   [0:HIDDEN-1];
	logic signed [31:0] mn_q, mx_q;
	logic signed [63:0] acc_q;
	logic signed [63:0] prod_q;
	logic signed [31:0] hsat_q;
	logic [15:0]        tk_q, tk1_q;
	logic [12:0]        tf_q;
	logic               tbig_q, tneg_q;

	// memory
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [31:0]   ram_rdata;
	logic          acc_in;
	logic          infer_in;

	assign acc_in   = s_axis_tvalid && s_axis_tready;
	assign infer_in = acc_in && (s_axis_tuser == mlp_pkg::REQ_INFER);
	assign ram_we   = acc_in && (s_axis_tuser == mlp_pkg::REQ_LOAD)
		&& (32'(s_axis_tdata[7:0]) < COEF_DEPTH);
	assign ram_waddr = AW'(s_axis_tdata[7:0]);

	mlp_ram #(.WIDTH(32), .DEPTH(COEF_DEPTH)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(s_axis_tdata[39:8]),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	mlp_pkg::div_req_t dreq;
	mlp_pkg::div_rsp_t drsp;
	mlp_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	// read address for the current step
	always_comb begin
		ram_raddr = '0;
		if (state_q == ST_NRD) begin
			if (nrd_q == 4'd0) ram_raddr = AW'(32'(f_q));
			else ram_raddr = AW'(MAX_B + 32'(f_q));
		end else if (state_q == ST_MRD) begin
			if (!layer_q) ram_raddr = AW'(HW_B + 32'(h_q) * FEATURES + 32'(f_q));
			else ram_raddr = AW'(OW_B + 32'(o_q) * HIDDEN + 32'(h_q));
		end else if (state_q == ST_ACC) begin
			if (!layer_q) ram_raddr = AW'(HB_B + 32'(h_q));
			else ram_raddr = AW'(OB_B + 32'(o_q));
		end
	end

	// divide operands: (x-mn)*2^17 / (mx-mn)
	logic signed [32:0] dnum;
	assign dnum = 33'(feat_q[f_q]) - 33'(mn_q);
	always_comb begin
		dreq.start = (state_q == ST_NRD) && (nrd_q == 4'd3) && (mx_q != mn_q);
		dreq.num   = 64'(dnum) <<< 17;
		dreq.den   = 33'(mx_q) - 33'(mn_q);
	end

	// shared multiplier operands: weight times feature or hidden output,
	// or the tanh slope times the fraction
	logic signed [31:0] mop;
	assign mop = layer_q ? he_q[h_q] : xn_q[f_q];

	logic signed [31:0] mul_a, mul_b;
	assign mul_a = (state_q == ST_TMUL) ? 32'(tk1_q - tk_q) : signed'(ram_rdata);
	assign mul_b = (state_q == ST_TMUL) ? 32'(tf_q) : mop;

	logic signed [63:0] bias_sum;
	assign bias_sum = acc_q + 64'(signed'(ram_rdata));

	logic [31:0] habs;
	assign habs = hsat_q[31] ? 32'(-hsat_q) : hsat_q;

	logic signed [31:0] tanh_y;
	assign tanh_y = 32'(signed'({16'd0, tk_q})) + 32'(prod_q >>> 13);

	logic last_f, last_h, last_o;
	assign last_f = (32'(f_q) == FEATURES - 1);
	assign last_h = (32'(h_q) == HIDDEN - 1);
	assign last_o = (32'(o_q) == OUTPUTS - 1);

	assign s_axis_tready = (state_q == ST_IDLE) && !m_axis_tvalid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			m_axis_tvalid <= 1'b0;
			nrd_q         <= '0;
			f_q           <= '0;
			h_q           <= '0;
			o_q           <= '0;
			layer_q       <= 1'b0;
		end else begin
			// output register: load a new word or drop the taken one
			if (state_q == ST_OUT && (!m_axis_tvalid || m_axis_tready))
				m_axis_tvalid <= 1'b1;
			else if (m_axis_tready)
				m_axis_tvalid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (infer_in) begin
						state_q <= ST_NRD;
						nrd_q   <= '0;
						f_q     <= '0;
						h_q     <= '0;
						o_q     <= '0;
						layer_q <= 1'b0;
					end
				end
				ST_NRD: begin
					// 0: read min, 1: min back, 2: max back, 3: start divide
					nrd_q <= nrd_q + 4'd1;
					if (nrd_q == 4'd3) begin
						nrd_q   <= '0;
						state_q <= ST_NDIV;
					end
				end
				ST_NDIV: begin
					if (mx_q == mn_q || drsp.done) begin
						if (last_f) begin
							f_q     <= '0;
							state_q <= ST_MRD;
						end else begin
							f_q     <= f_q + FW'(1);
							state_q <= ST_NRD;
						end
					end
				end
				ST_MRD: state_q <= ST_MUL;
				ST_MUL: state_q <= ST_ACC;
				ST_ACC: begin
					if (!layer_q) begin
						if (last_f) begin
							f_q     <= '0;
							state_q <= ST_BIAS;
						end else begin
							f_q     <= f_q + FW'(1);
							state_q <= ST_MRD;
						end
					end else begin
						if (last_h) begin
							h_q     <= '0;
							state_q <= ST_BIAS;
						end else begin
							h_q     <= h_q + HWD'(1);
							state_q <= ST_MRD;
						end
					end
				end
				ST_BIAS: state_q <= layer_q ? ST_OUT : ST_TANH;
				ST_TANH: state_q <= ST_TMUL;
				ST_TMUL: state_q <= ST_TEND;
				ST_TEND: begin
					if (last_h) begin
						h_q     <= '0;
						layer_q <= 1'b1;
					end else begin
						h_q <= h_q + HWD'(1);
					end
					state_q <= ST_MRD;
				end
				ST_OUT: begin
					if (!m_axis_tvalid || m_axis_tready) begin
						if (last_o) state_q <= ST_WAIT;
						else begin
							o_q     <= o_q + OWD'(1);
							state_q <= ST_MRD;
						end
					end
				end
				ST_WAIT: if (!m_axis_tvalid || m_axis_tready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (infer_in) begin
			for (int i = 0; i < FEATURES; i++)
				feat_q[i] <= s_axis_tdata[40 + 32*i +: 32];
			acc_q <= '0;
		end
		if (state_q == ST_NRD && nrd_q == 4'd1) mn_q <= ram_rdata;
		if (state_q == ST_NRD && nrd_q == 4'd2) mx_q <= ram_rdata;
		if (state_q == ST_NDIV) begin
			if (mx_q == mn_q) xn_q[f_q] <= '0;
			else if (drsp.done) xn_q[f_q] <= mlp_pkg::sat32(drsp.quo - 64'sd65536);
		end
		if (state_q == ST_MUL || state_q == ST_TMUL) prod_q <= mul_a * mul_b;
		if (state_q == ST_ACC) acc_q <= acc_q + (prod_q >>> mlp_pkg::Q_FRAC);
		if (state_q == ST_BIAS) hsat_q <= mlp_pkg::sat32(bias_sum);
		if (state_q == ST_TANH) begin
			tbig_q <= habs >= 32'd262144;
			tneg_q <= hsat_q[31];
			tk_q   <= mlp_pkg::TANH_TAB[6'(habs[17:13])];
			tk1_q  <= mlp_pkg::TANH_TAB[6'(habs[17:13]) + 6'd1];
			tf_q   <= habs[12:0];
		end
		if (state_q == ST_TEND) begin
			if (tbig_q) he_q[h_q] <= tneg_q ? -32'sd65492 : 32'sd65492;
			else he_q[h_q] <= tneg_q ? -tanh_y : tanh_y;
			acc_q <= '0;
		end
		if (state_q == ST_OUT && (!m_axis_tvalid || m_axis_tready)) begin
			m_axis_tdata <= {6'd0, 2'(o_q), hsat_q};
			m_axis_tlast <= last_o;
			acc_q        <= '0;
		end
	end

	// output word never changes while waiting
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("output word changed under stall");
	// no input taken while a sample runs
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !s_axis_tready)
		else $error("ready while busy");
	// divide completes only while waiting for it
	a_div: assert property (@(posedge clk) disable iff (!arst_n)
		drsp.done |-> state_q == ST_NDIV)
		else $error("stray divide result");
endmodule

// ===== sim/mlp_one_hidden_layer_inference_test.sv =====
// testbench for the one-hidden-layer perceptron inference engine
// drives load and sample words, predicts results in q16.16 and checks them
// depends on mlp_pkg and mlp_one_hidden_layer_inference
module mlp_one_hidden_layer_inference_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NFEAT = 8;
	localparam int NHID = 12;
	localparam int NOUT = 1;
	localparam int MIN_AT = 0;
	localparam int MAX_AT = NFEAT;
	localparam int HW_AT = 2 * NFEAT;
	localparam int HB_AT = HW_AT + NHID * NFEAT;
	localparam int OW_AT = HB_AT + NHID;
	localparam int OB_AT = OW_AT + NOUT * NHID;
	localparam int NCOEF = OB_AT + NOUT;

	typedef struct {
		logic signed [31:0] pred;
		logic [1:0] idx;
		logic last;
	} pred_word_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [295:0] s_axis_tdata;
	logic s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [39:0] m_axis_tdata;
	logic m_axis_tlast;

	// model copy of the coefficient memory
	logic signed [31:0] coef_mem [0:255];
	pred_word_t pending_preds [$];
	int errors;
	bit no_idle;

	mlp_one_hidden_layer_inference dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// hard stop: a few dozen samples plus stalls, with a wide margin
	initial begin
		#2ms;
		$display("mlp_one_hidden_layer_inference_test: FAIL");
		$finish;
	end

	function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// product shifted right by 16, rounding toward minus infinity
	function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [63:0] p;
		p = a * b;
		return p >>> 16;
	endfunction

	function automatic logic signed [63:0] norm_feature(input logic signed [63:0] x,
			input logic signed [63:0] lo, input logic signed [63:0] hi);
		logic signed [63:0] span;
		span = hi - lo;
		if (span == 0) return 64'sd0;
		return clamp32((x - lo) * 64'sd131072 / span - 64'sd65536);
	endfunction

	function automatic logic signed [63:0] tanh_lookup(input logic signed [63:0] h);
		logic signed [63:0] a, y, d, fr;
		int k;
		a = (h < 0) ? -h : h;
		if (a >= 64'sd262144) y = $signed({48'd0, mlp_pkg::TANH_TAB[32]});
		else begin
			k = int'(a >>> 13);
			fr = a & 64'sd8191;
			d = $signed({48'd0, mlp_pkg::TANH_TAB[k + 1]})
				- $signed({48'd0, mlp_pkg::TANH_TAB[k]});
			y = $signed({48'd0, mlp_pkg::TANH_TAB[k]}) + ((d * fr) >>> 13);
		end
		return (h < 0) ? -y : y;
	endfunction

	// expected output words of one sample under the current coefficients
	task automatic predict_sample(input logic signed [31:0] feat [NFEAT]);
		logic signed [63:0] xn [NFEAT];
		logic signed [63:0] he [NHID];
		logic signed [63:0] acc;
		pred_word_t w;
		for (int f = 0; f < NFEAT; f++)
			xn[f] = norm_feature(feat[f], coef_mem[MIN_AT + f], coef_mem[MAX_AT + f]);
		for (int h = 0; h < NHID; h++) begin
			acc = 0;
			for (int f = 0; f < NFEAT; f++)
				acc += qmul(coef_mem[HW_AT + h * NFEAT + f], xn[f]);
			acc += coef_mem[HB_AT + h];
			he[h] = tanh_lookup(clamp32(acc));
		end
		for (int o = 0; o < NOUT; o++) begin
			acc = 0;
			for (int h = 0; h < NHID; h++)
				acc += qmul(coef_mem[OW_AT + o * NHID + h], he[h]);
			acc += coef_mem[OB_AT + o];
			w.pred = 32'(clamp32(acc));
			w.idx = o[1:0];
			w.last = (o == NOUT - 1);
			pending_preds.insert(pending_preds.size(), w);
		end
	endtask

	function automatic bit idle_now();
		return !no_idle && ($urandom_range(99) < 34);
	endfunction

	// drive one word and wait for its handshake; valid stays up until the
	// next word or an idle cycle takes it down
	task automatic send_word(input logic req, input logic [7:0] addr,
			input logic signed [31:0] val, input logic signed [31:0] feat [NFEAT]);
		logic [295:0] d;
		while (idle_now()) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		d = '0;
		d[7:0] = addr;
		d[39:8] = val;
		for (int f = 0; f < NFEAT; f++) d[40 + 32 * f +: 32] = feat[f];
		s_axis_tdata <= d;
		s_axis_tuser <= req;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		if (req == mlp_pkg::REQ_LOAD) coef_mem[addr] = val;
		else predict_sample(feat);
		@(negedge clk);
	endtask

	function automatic logic signed [31:0] rand_word();
		case ($urandom_range(5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return $signed($urandom_range(131072)) - 32'sd65536;
			3: return $signed($urandom_range(8 << 16)) - 32'sd262144;
			default: return $urandom;
		endcase
	endfunction

	task automatic load_coef(input int addr, input logic signed [31:0] val);
		logic signed [31:0] nofeat [NFEAT];
		foreach (nofeat[i]) nofeat[i] = $urandom;
		send_word(mlp_pkg::REQ_LOAD, addr[7:0], val, nofeat);
	endtask

	task automatic send_sample(input logic signed [31:0] feat [NFEAT]);
		send_word(mlp_pkg::REQ_INFER, 8'($urandom), $urandom, feat);
	endtask

	// a sensible coefficient set: ranges around the features, modest weights
	task automatic load_sane_net();
		logic signed [31:0] lo;
		for (int f = 0; f < NFEAT; f++) begin
			lo = $signed($urandom_range(1 << 20)) - 32'sd524288;
			load_coef(MIN_AT + f, lo);
			load_coef(MAX_AT + f, lo + ($urandom_range(3) == 0 ? 0 : $urandom_range(1 << 20)));
		end
		for (int i = HW_AT; i < NCOEF; i++)
			load_coef(i, $signed($urandom_range(1 << 18)) - 32'sd131072);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_preds.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	// extremes of the features and coefficients, zero range, inverted range
	task automatic test_directed();
		logic signed [31:0] feat [NFEAT];
		for (int i = 0; i < NCOEF; i++) load_coef(i, 32'sh7fffffff);
		foreach (feat[i]) feat[i] = 32'sh80000000;
		send_sample(feat);
		for (int i = 0; i < NCOEF; i++) load_coef(i, 32'sh80000000);
		foreach (feat[i]) feat[i] = 32'sh7fffffff;
		send_sample(feat);
		load_sane_net();
		load_coef(MIN_AT, 32'sd65536);
		load_coef(MAX_AT, 32'sd65536);      // zero range
		load_coef(MIN_AT + 1, 32'sd65536);
		load_coef(MAX_AT + 1, -32'sd65536); // max below min
		foreach (feat[i]) feat[i] = rand_word();
		send_sample(feat);
		foreach (feat[i]) feat[i] = 0;
		send_sample(feat);
		load_coef(255, 32'sh7fffffff);       // top address, unused by the net
		load_coef(255, 32'sh80000000);
		wait_drained();
	endtask

	task automatic test_random(input int n_items);
		logic signed [31:0] feat [NFEAT];
		int sent;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(9) == 0 && n_items - sent >= NCOEF) begin
				load_sane_net();
				sent += NCOEF;
			end else if ($urandom_range(3) == 0) begin
				load_coef($urandom_range(255), rand_word());
				sent++;
			end else begin
				foreach (feat[i]) feat[i] = ($urandom_range(2) == 0) ? rand_word()
					: $signed($urandom_range(1 << 21)) - 32'sd1048576;
				send_sample(feat);
				sent++;
			end
		end
		wait_drained();
	endtask

	// output side: random stall and checking of each word
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_axis_tready <= !idle_now();
		end
	end

	always @(posedge clk) begin
		pred_word_t w;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_preds.size() == 0) begin
				$display("%t: unexpected word, got %h last %b", $time,
					m_axis_tdata, m_axis_tlast);
				errors++;
			end else begin
				w = pending_preds.pop_front();
				if (m_axis_tdata[31:0] !== w.pred || m_axis_tdata[33:32] !== w.idx
						|| m_axis_tlast !== w.last) begin
					$display("%t: mismatch, expected %h idx %0d last %b, got %h idx %0d last %b",
						$time, w.pred, w.idx, w.last, m_axis_tdata[31:0],
						m_axis_tdata[33:32], m_axis_tlast);
					errors++;
				end
			end
		end
	end

	initial begin
		errors = 0;
		no_idle = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = mlp_pkg::REQ_LOAD;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		// every coefficient entry that the net reads is written before any random sample
		test_random(20);
		no_idle = 1'b1;
		test_random(8);
		no_idle = 1'b0;
		test_random(12);
		wait_drained();
		if (errors == 0 && pending_preds.size() == 0)
			$display("mlp_one_hidden_layer_inference_test: PASS");
		else
			$display("mlp_one_hidden_layer_inference_test: FAIL");
		$finish;
	end
endmodule

// ===== files.f =====
sv/mlp_pkg.sv
sv/mlp_ram.sv
sv/mlp_div.sv
sv/mlp_one_hidden_layer_inference.sv
sim/mlp_one_hidden_layer_inference_test.sv
